@@ hw/rtl/gcb_pkg.sv @@
package gcb_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 20;
   localparam int CORDIC_STEPS_DEF    = 24;

   // fixed internal formats
   localparam int ZF     = 32;   // angle fraction bits inside
   localparam int VF     = 30;   // sine/cosine fraction bits
   localparam int Z_W    = 42;   // angle accumulator, Q32 degrees
   localparam int SC_W   = 32;   // sine/cosine datapath
   localparam int MUL_W  = 33;   // reduced product
   localparam int VEC_W  = 36;   // vectoring datapath
   localparam int ANG_W  = 31;   // input angle and longitude difference
   localparam int WRAP_W = 36;   // range reduction word
   localparam int HEAD_W = 29;
   localparam int BRG_W  = 29;
   localparam int CORR_W = 31;

   localparam logic signed [SC_W-1:0] GAIN_Q30 = 32'sd652032874;

   typedef struct packed {
      logic signed [SC_W-1:0] x;
      logic signed [SC_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   neg;
   } rot_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] px;
      logic signed [VEC_W-1:0] py;
      logic signed [Z_W-1:0]   z;
      logic                    zero;
   } vec_type;

   typedef struct packed {
      logic              valid;
      logic [HEAD_W-1:0] head;
   } side_type;

   // atan(2^-i) in degrees, Q32, rounded
   function automatic logic signed [Z_W-1:0] atan_q32(input int unsigned i);
      logic signed [Z_W-1:0] v;
      case (i)
         0:  v = 42'sd193273528320;
         1:  v = 42'sd114096026022;
         2:  v = 42'sd60285206653;
         3:  v = 42'sd30601712202;
         4:  v = 42'sd15360239180;
         5:  v = 42'sd7687607525;
         6:  v = 42'sd3844741810;
         7:  v = 42'sd1922488225;
         8:  v = 42'sd961258780;
         9:  v = 42'sd480631223;
         10: v = 42'sd240315841;
         11: v = 42'sd120157949;
         12: v = 42'sd60078978;
         13: v = 42'sd30039489;
         14: v = 42'sd15019745;
         15: v = 42'sd7509872;
         16: v = 42'sd3754936;
         17: v = 42'sd1877468;
         18: v = 42'sd938734;
         19: v = 42'sd469367;
         20: v = 42'sd234684;
         21: v = 42'sd117342;
         22: v = 42'sd58671;
         23: v = 42'sd29335;
         24: v = 42'sd14668;
         25: v = 42'sd7334;
         26: v = 42'sd3667;
         27: v = 42'sd1833;
         28: v = 42'sd917;
         29: v = 42'sd458;
         30: v = 42'sd229;
         31: v = 42'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/gcb_wrap_cell.sv @@
module gcb_wrap_cell
   import gcb_pkg::*;
#(
   parameter logic signed [WRAP_W-1:0] MODULUS = '1
) (
   input  logic                     clock,
   input  logic signed [WRAP_W-1:0] u_i,
   output logic signed [WRAP_W-1:0] u_o
);

   logic signed [WRAP_W-1:0] u_in;
   logic signed [WRAP_W-1:0] u_ff;

   // drop one multiple of the turn when it fits
   always_comb begin
      u_in = (u_i >= MODULUS) ? u_i - MODULUS : u_i;
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
   end

   assign u_o = u_ff;

endmodule

@@ hw/rtl/gcb_rot_cell.sv @@
module gcb_rot_cell
   import gcb_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  rot_type stage_i,
   output rot_type stage_o
);

   localparam logic signed [Z_W-1:0] ATAN = atan_q32(STEP);

   rot_type                st_in;
   rot_type                st_ff;
   logic signed [SC_W-1:0] dx;
   logic signed [SC_W-1:0] dy;

   always_comb begin
      dx    = stage_i.y >>> STEP;
      dy    = stage_i.x >>> STEP;
      st_in = stage_i;
      if (stage_i.z >= 0) begin
         st_in.x = stage_i.x - dx;
         st_in.y = stage_i.y + dy;
         st_in.z = stage_i.z - ATAN;
      end else begin
         st_in.x = stage_i.x + dx;
         st_in.y = stage_i.y - dy;
         st_in.z = stage_i.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign stage_o = st_ff;

endmodule

@@ hw/rtl/gcb_vec_cell.sv @@
module gcb_vec_cell
   import gcb_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  vec_type stage_i,
   output vec_type stage_o
);

   localparam logic signed [Z_W-1:0] ATAN = atan_q32(STEP);

   vec_type                 st_in;
   vec_type                 st_ff;
   logic signed [VEC_W-1:0] dx;
   logic signed [VEC_W-1:0] dy;

   // drive the second coordinate towards zero
   always_comb begin
      dx    = stage_i.py >>> STEP;
      dy    = stage_i.px >>> STEP;
      st_in = stage_i;
      if (stage_i.py > 0) begin
         st_in.px = stage_i.px + dx;
         st_in.py = stage_i.py - dy;
         st_in.z  = stage_i.z + ATAN;
      end else begin
         st_in.px = stage_i.px - dx;
         st_in.py = stage_i.py + dy;
         st_in.z  = stage_i.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   assign stage_o = st_ff;

endmodule

@@ hw/rtl/great_circle_bearing_correction_unit.sv @@
// Throughput: one beat per cycle; busy never rises, every stage is a register.
// rsp_valid is high for one cycle per result; the receiver cannot stall.
// Reset (synchronous) clears the valid flags and the side-pipe headings only; data in flight is dropped.
module great_circle_bearing_correction_unit
   import gcb_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [27:0]       req_start_lat,
   input  logic signed [28:0]       req_start_lon,
   input  logic signed [27:0]       req_target_lat,
   input  logic signed [28:0]       req_target_lon,
   input  logic [HEAD_W-1:0]        req_current_heading,
   output logic                     rsp_valid,
   output logic signed [BRG_W-1:0]  rsp_bearing,
   output logic signed [CORR_W-1:0] rsp_course_correction
);

   // Range reduction: add half a turn plus a multiple of 360 degrees large enough
   // to make the angle non-negative, then strip binary multiples of 360 from the top down.
   localparam int WRAP_K = (ANGLE_FRAC_BITS >= 23) ? 0 : 23 - ANGLE_FRAC_BITS;
   localparam logic signed [WRAP_W-1:0] HALF_TURN =
      WRAP_W'(64'd180 << ANGLE_FRAC_BITS);
   localparam logic signed [WRAP_W-1:0] QUARTER_TURN =
      WRAP_W'(64'd90 << ANGLE_FRAC_BITS);
   localparam logic signed [WRAP_W-1:0] WRAP_OFFSET =
      WRAP_W'((64'd180 << ANGLE_FRAC_BITS) + (64'd360 << (ANGLE_FRAC_BITS + WRAP_K)));
   localparam int ZSHIFT = ZF - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0] RIGHT_Q32 = Z_W'(64'd90 << ZF);
   localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(64'd1 << (ZSHIFT - 1));
   localparam logic signed [Z_W-1:0] BRG_LIM = Z_W'(64'd180 << ANGLE_FRAC_BITS);
   // stages ahead of the output register
   localparam int SIDE_D = 7 + WRAP_K + 2 * CORDIC_STEPS;
   localparam int LANES  = 3;   // start latitude, target latitude, longitude difference

   // accept every cycle
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // Side pipe: valid flag and heading travel alongside the datapath.
   // ---------------------------------------------------------------
   side_type side_ff [SIDE_D];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SIDE_D; j++) begin
            side_ff[j] <= '0;
         end
      end else begin
         side_ff[0].valid <= start & ~busy;
         side_ff[0].head  <= req_current_heading;
         for (int j = 1; j < SIDE_D; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Capture the beat; form the longitude difference in input units.
   // ---------------------------------------------------------------
   logic signed [ANG_W-1:0] ang_ff [LANES];

   always_ff @(posedge clock) begin
      ang_ff[0] <= ANG_W'(req_start_lat);
      ang_ff[1] <= ANG_W'(req_target_lat);
      ang_ff[2] <= ANG_W'(req_target_lon) - ANG_W'(req_start_lon);
   end

   // ---------------------------------------------------------------
   // Offset into positive range, then the chain of reduction cells.
   // ---------------------------------------------------------------
   logic signed [WRAP_W-1:0] wrap_s [WRAP_K+2][LANES];

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         wrap_s[0][l] <= WRAP_W'(ang_ff[l]) + WRAP_OFFSET;
      end
   end

   for (genvar j = 0; j <= WRAP_K; j++) begin : g_wrap
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         gcb_wrap_cell #(
            .MODULUS(WRAP_W'(64'd360 << (ANGLE_FRAC_BITS + WRAP_K - j)))
         ) u_cell (
            .clock (clock),
            .u_i   (wrap_s[j][l]),
            .u_o   (wrap_s[j+1][l])
         );
      end
   end

   // ---------------------------------------------------------------
   // Centre on zero, fold into +-90 degrees, scale to Q32 and seed
   // the rotation with the CORDIC gain.
   // ---------------------------------------------------------------
   rot_type rot_s [CORDIC_STEPS+1][LANES];
   rot_type seed_in [LANES];

   always_comb begin
      logic signed [WRAP_W-1:0] r_v;
      logic signed [WRAP_W-1:0] a_v;
      logic                     neg_v;
      for (int l = 0; l < LANES; l++) begin
         r_v   = wrap_s[WRAP_K+1][l] - HALF_TURN;
         a_v   = r_v;
         neg_v = 1'b0;
         if (r_v > QUARTER_TURN) begin
            a_v   = HALF_TURN - r_v;
            neg_v = 1'b1;
         end else if (r_v < -QUARTER_TURN) begin
            a_v   = -HALF_TURN - r_v;
            neg_v = 1'b1;
         end
         seed_in[l].x   = GAIN_Q30;
         seed_in[l].y   = '0;
         seed_in[l].z   = Z_W'(a_v) <<< ZSHIFT;
         seed_in[l].neg = neg_v;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         rot_s[0][l] <= seed_in[l];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         gcb_rot_cell #(
            .STEP(i)
         ) u_cell (
            .clock   (clock),
            .stage_i (rot_s[i][l]),
            .stage_o (rot_s[i+1][l])
         );
      end
   end

   // ---------------------------------------------------------------
   // Products: first rank gives x, cos1*sin2 and sin1*cos2 in Q30.
   // ---------------------------------------------------------------
   logic signed [SC_W-1:0]   sin_v [LANES];
   logic signed [SC_W-1:0]   cos_v [LANES];
   logic signed [2*SC_W-1:0] prod_x;
   logic signed [2*SC_W-1:0] prod_p;
   logic signed [2*SC_W-1:0] prod_t;
   logic signed [MUL_W-1:0]  x_ff;
   logic signed [MUL_W-1:0]  p1_ff;
   logic signed [MUL_W-1:0]  t_ff;
   logic signed [SC_W-1:0]   cd_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sin_v[l] = rot_s[CORDIC_STEPS][l].y;
         cos_v[l] = rot_s[CORDIC_STEPS][l].neg ? -rot_s[CORDIC_STEPS][l].x
                                               : rot_s[CORDIC_STEPS][l].x;
      end
      prod_x = cos_v[1] * sin_v[2];
      prod_p = cos_v[0] * sin_v[1];
      prod_t = sin_v[0] * cos_v[1];
   end

   always_ff @(posedge clock) begin
      x_ff  <= MUL_W'(prod_x >>> VF);
      p1_ff <= MUL_W'(prod_p >>> VF);
      t_ff  <= MUL_W'(prod_t >>> VF);
      cd_ff <= cos_v[2];
   end

   // second rank: y = cos1*sin2 - (sin1*cos2)*cos(dlon)
   logic signed [MUL_W+SC_W-1:0] prod_q;
   logic signed [VEC_W-1:0]      x2_ff;
   logic signed [VEC_W-1:0]      y_ff;

   assign prod_q = t_ff * cd_ff;

   always_ff @(posedge clock) begin
      x2_ff <= VEC_W'(x_ff);
      y_ff  <= VEC_W'(p1_ff) - VEC_W'(prod_q >>> VF);
   end

   // ---------------------------------------------------------------
   // Vectoring: turn into the right half-plane, then the cell chain.
   // ---------------------------------------------------------------
   vec_type vec_s [CORDIC_STEPS+1];
   vec_type pre_in;

   always_comb begin
      pre_in.px   = y_ff;
      pre_in.py   = x2_ff;
      pre_in.z    = '0;
      pre_in.zero = (y_ff == '0) && (x2_ff == '0);
      if (y_ff < 0) begin
         if (x2_ff >= 0) begin
            pre_in.px = x2_ff;
            pre_in.py = -y_ff;
            pre_in.z  = RIGHT_Q32;
         end else begin
            pre_in.px = -x2_ff;
            pre_in.py = y_ff;
            pre_in.z  = -RIGHT_Q32;
         end
      end
   end

   always_ff @(posedge clock) begin
      vec_s[0] <= pre_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      gcb_vec_cell #(
         .STEP(i)
      ) u_cell (
         .clock   (clock),
         .stage_i (vec_s[i]),
         .stage_o (vec_s[i+1])
      );
   end

   // ---------------------------------------------------------------
   // Round to output units, clamp to +-180, subtract the heading.
   // ---------------------------------------------------------------
   logic signed [Z_W-1:0]    z_v;
   logic signed [Z_W-1:0]    brg_v;
   logic signed [Z_W-1:0]    corr_v;
   logic                     rsp_valid_ff;
   logic signed [BRG_W-1:0]  brg_ff;
   logic signed [CORR_W-1:0] corr_ff;

   always_comb begin
      z_v   = vec_s[CORDIC_STEPS].zero ? '0 : vec_s[CORDIC_STEPS].z;
      brg_v = (z_v + ROUND_HALF) >>> ZSHIFT;
      if (brg_v > BRG_LIM) begin
         brg_v = BRG_LIM;
      end else if (brg_v < -BRG_LIM) begin
         brg_v = -BRG_LIM;
      end
      corr_v = brg_v - $signed(Z_W'(side_ff[SIDE_D-1].head));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_ff[SIDE_D-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      brg_ff  <= brg_v[BRG_W-1:0];
      corr_ff <= corr_v[CORR_W-1:0];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_bearing           = brg_ff;
   assign rsp_course_correction = corr_ff;

endmodule
